### rtl/pngenc_pkg.sv
// Package: shared types, constants and checksum helpers for the PNG stream encoder.
package pngenc_pkg;

  localparam int unsigned DimW = 14;
  localparam int unsigned IdxW = 6;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 2'd1;

  localparam logic [DimW-1:0] WIDTH_RST  = 14'd640;
  localparam logic [DimW-1:0] HEIGHT_RST = 14'd480;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;

  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  localparam logic [31:0] TAG_IHDR = 32'h4948_4452;
  localparam logic [31:0] TAG_IDAT = 32'h4944_4154;
  localparam logic [31:0] TAG_IEND = 32'h4945_4E44;
  localparam logic [31:0] IHDR_LEN = 32'd13;

  localparam logic [IdxW-1:0] START_LAST  = 6'd42;
  localparam logic [IdxW-1:0] PIX_FIRST   = 6'd6;
  localparam logic [IdxW-1:0] PIX_LAST    = 6'd9;
  localparam logic [IdxW-1:0] FRAME_LAST  = 6'd29;

  typedef enum logic {
    CMD_START,
    CMD_PIXEL
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e       kind;
    logic            row_start;
    logic            last_row;
    logic            frame_end;
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
    logic [31:0]     idat_len;
    logic [31:0]     pixel;
  } cmd_t;

  function automatic logic [7:0] sig_byte(input logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0:    b = 8'd137;
      3'd1:    b = 8'd80;
      3'd2:    b = 8'd78;
      3'd3:    b = 8'd71;
      3'd4:    b = 8'd13;
      3'd5:    b = 8'd10;
      3'd6:    b = 8'd26;
      default: b = 8'd10;
    endcase
    return b;
  endfunction

  // Big-endian byte k of a word
  function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0:    b = v[31:24];
      2'd1:    b = v[23:16];
      2'd2:    b = v[15:8];
      default: b = v[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### rtl/pngenc_if.sv
// Interfaces: input item channel and output byte channel.
interface pngenc_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] pixel;
  modport source (output valid, output action, output pixel, input ready);
  modport sink (input valid, input action, input pixel, output ready);
endinterface

interface pngenc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       file_end;
  modport source (output valid, output out_byte, output run_last, output file_end,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input file_end,
                output ready);
endinterface

### rtl/pngenc_front.sv
// Front end: config registers, frame tracking and command classification.
module pngenc_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pngenc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [pngenc_pkg::DimW-1:0]         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                action_i,
  input  logic [31:0]                         pixel_i,
  input  logic                                q_full_i,
  output logic                                q_push_o,
  output pngenc_pkg::cmd_t                    q_cmd_o
);

  logic [pngenc_pkg::DimW-1:0] width_q, height_q;
  logic [pngenc_pkg::DimW-1:0] col_q, col_d, row_q, row_d;
  logic                        open_q, open_d;
  logic [pngenc_pkg::DimW-1:0] w_eff, h_eff;
  logic [pngenc_pkg::DimW:0]   col_inc, row_inc;
  logic                        accept, row_end, last_row;
  logic [16:0]                 row_cost;
  logic [30:0]                 prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= pngenc_pkg::WIDTH_RST;
      height_q <= pngenc_pkg::HEIGHT_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == pngenc_pkg::CFG_WIDTH) width_q <= cfg_data_i;
      else if (cfg_idx_i == pngenc_pkg::CFG_HEIGHT) height_q <= cfg_data_i;
    end
  end

  assign w_eff    = (width_q == '0) ? 14'd1 : width_q;
  assign h_eff    = (height_q == '0) ? 14'd1 : height_q;
  assign col_inc  = {1'b0, col_q} + 15'd1;
  assign row_inc  = {1'b0, row_q} + 15'd1;
  assign row_end  = col_inc >= {1'b0, w_eff};
  assign last_row = row_inc >= {1'b0, h_eff};
  assign row_cost = {1'b0, w_eff, 2'b00} + 17'd6;
  assign prod     = 31'(h_eff) * 31'(row_cost);

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    open_d   = open_q;
    col_d    = col_q;
    row_d    = row_q;
    q_push_o = 1'b0;
    q_cmd_o.kind      = (action_i == pngenc_pkg::ACT_START) ? pngenc_pkg::CMD_START
                                                             : pngenc_pkg::CMD_PIXEL;
    q_cmd_o.row_start = (col_q == '0);
    q_cmd_o.last_row  = last_row;
    q_cmd_o.frame_end = row_end && last_row;
    q_cmd_o.width     = w_eff;
    q_cmd_o.height    = h_eff;
    q_cmd_o.idat_len  = 32'd6 + {1'b0, prod};
    q_cmd_o.pixel     = pixel_i;
    if (accept) begin
      if (action_i == pngenc_pkg::ACT_START) begin
        q_push_o = 1'b1;
        open_d   = 1'b1;
        col_d    = '0;
        row_d    = '0;
      end else if (open_q) begin
        q_push_o = 1'b1;
        if (row_end) begin
          col_d = '0;
          if (last_row) begin
            row_d  = '0;
            open_d = 1'b0;
          end else begin
            row_d = row_inc[pngenc_pkg::DimW-1:0];
          end
        end else begin
          col_d = col_inc[pngenc_pkg::DimW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      col_q  <= '0;
      row_q  <= '0;
    end else begin
      open_q <= open_d;
      col_q  <= col_d;
      row_q  <= row_d;
    end
  end

endmodule

### rtl/pngenc_queue.sv
// Two-entry command queue between front and back end.
module pngenc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pngenc_pkg::cmd_t cmd_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output pngenc_pkg::cmd_t cmd_o
);

  pngenc_pkg::cmd_t mem_q [2];
  logic             wp_q, wp_d, rp_q, rp_d;
  logic [1:0]       cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign cmd_o   = mem_q[rp_q];

  always_comb begin
    wp_d  = push_i ? ~wp_q : wp_q;
    rp_d  = pop_i ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### rtl/pngenc_back.sv
// Back end: byte sequencer with CRC-32, Adler-32 and an output register.
module pngenc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  pngenc_pkg::cmd_t q_cmd_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             run_last_o,
  output logic             file_end_o
);

  pngenc_pkg::cmd_t            cmd_q;
  logic                        busy_q, busy_d;
  logic [pngenc_pkg::IdxW-1:0] idx_q, idx_d, last_idx;
  logic [31:0]                 crc_q, crc_src;
  logic [15:0]                 alo_q, ahi_q, alo_src, ahi_src;
  logic [16:0]                 alo_sum, ahi_sum;
  logic [15:0]                 alo_n, ahi_n;
  logic                        ov_q, advance, done, load;
  logic [7:0]                  b;
  logic                        to_crc, crc_rst, to_adl, adl_rst, is_end;
  logic [15:0]                 blen, bnlen;
  logic [1:0]                  k_a, k_b;
  logic [7:0]                  byte_q;
  logic                        rl_q, fe_q;

  assign advance = busy_q && (!ov_q || out_ready_i);
  assign last_idx = (cmd_q.kind == pngenc_pkg::CMD_START) ? pngenc_pkg::START_LAST :
                    (cmd_q.frame_end ? pngenc_pkg::FRAME_LAST : pngenc_pkg::PIX_LAST);
  assign done    = advance && (idx_q == last_idx);
  assign load    = q_valid_i && (!busy_q || done);
  assign q_pop_o = load;
  assign blen    = {cmd_q.width, 2'b01};
  assign bnlen   = ~blen;
  assign k_a     = idx_q[1:0];
  assign k_b     = idx_q[1:0] + 2'd3;
  assign is_end  = (cmd_q.kind == pngenc_pkg::CMD_PIXEL) && (idx_q == pngenc_pkg::FRAME_LAST);

  // Byte generator
  always_comb begin
    b       = 8'd0;
    to_crc  = 1'b0;
    crc_rst = 1'b0;
    to_adl  = 1'b0;
    adl_rst = 1'b0;
    if (cmd_q.kind == pngenc_pkg::CMD_START) begin
      adl_rst = (idx_q == '0);
      case (idx_q) inside
        [6'd0:6'd7]:   b = pngenc_pkg::sig_byte(idx_q[2:0]);
        [6'd8:6'd11]:  b = pngenc_pkg::be_byte(pngenc_pkg::IHDR_LEN, k_a);
        [6'd12:6'd15]: begin
          b = pngenc_pkg::be_byte(pngenc_pkg::TAG_IHDR, k_a);
          to_crc = 1'b1;
          crc_rst = (idx_q == 6'd12);
        end
        [6'd16:6'd19]: begin
          b = pngenc_pkg::be_byte({18'd0, cmd_q.width}, k_a);
          to_crc = 1'b1;
        end
        [6'd20:6'd23]: begin
          b = pngenc_pkg::be_byte({18'd0, cmd_q.height}, k_a);
          to_crc = 1'b1;
        end
        6'd24: begin
          b = 8'd8;
          to_crc = 1'b1;
        end
        6'd25: begin
          b = 8'd6;
          to_crc = 1'b1;
        end
        [6'd26:6'd28]: to_crc = 1'b1;
        [6'd29:6'd32]: b = pngenc_pkg::be_byte(~crc_q, k_b);
        [6'd33:6'd36]: b = pngenc_pkg::be_byte(cmd_q.idat_len, k_b);
        [6'd37:6'd40]: begin
          b = pngenc_pkg::be_byte(pngenc_pkg::TAG_IDAT, k_b);
          to_crc = 1'b1;
          crc_rst = (idx_q == 6'd37);
        end
        6'd41: begin
          b = 8'h78;
          to_crc = 1'b1;
        end
        default: begin
          b = 8'h01;
          to_crc = 1'b1;
        end
      endcase
    end else begin
      case (idx_q) inside
        6'd0: begin
          b = {7'd0, cmd_q.last_row};
          to_crc = 1'b1;
        end
        6'd1: begin
          b = blen[7:0];
          to_crc = 1'b1;
        end
        6'd2: begin
          b = blen[15:8];
          to_crc = 1'b1;
        end
        6'd3: begin
          b = bnlen[7:0];
          to_crc = 1'b1;
        end
        6'd4: begin
          b = bnlen[15:8];
          to_crc = 1'b1;
        end
        6'd5: begin
          to_crc = 1'b1;
          to_adl = 1'b1;
        end
        [6'd6:6'd9]: begin
          b = pngenc_pkg::be_byte({cmd_q.pixel[23:0], cmd_q.pixel[31:24]}, idx_q[1:0] + 2'd2);
          to_crc = 1'b1;
          to_adl = 1'b1;
        end
        [6'd10:6'd13]: begin
          b = pngenc_pkg::be_byte({ahi_q, alo_q}, idx_q[1:0] + 2'd2);
          to_crc = 1'b1;
        end
        [6'd14:6'd17]: b = pngenc_pkg::be_byte(~crc_q, idx_q[1:0] + 2'd2);
        [6'd22:6'd25]: begin
          b = pngenc_pkg::be_byte(pngenc_pkg::TAG_IEND, idx_q[1:0] + 2'd2);
          to_crc = 1'b1;
          crc_rst = (idx_q == 6'd22);
        end
        [6'd26:6'd29]: b = pngenc_pkg::be_byte(~crc_q, idx_q[1:0] + 2'd2);
        default: b = 8'd0;
      endcase
    end
  end

  // Checksum datapath
  always_comb begin
    crc_src = crc_rst ? pngenc_pkg::CRC_INIT : crc_q;
    alo_src = adl_rst ? 16'd1 : alo_q;
    ahi_src = adl_rst ? 16'd0 : ahi_q;
    alo_sum = {1'b0, alo_src} + {9'd0, b};
    alo_n   = (alo_sum >= pngenc_pkg::ADLER_MOD) ? 16'(alo_sum - pngenc_pkg::ADLER_MOD)
                                                 : alo_sum[15:0];
    ahi_sum = {1'b0, ahi_src} + {1'b0, alo_n};
    ahi_n   = (ahi_sum >= pngenc_pkg::ADLER_MOD) ? 16'(ahi_sum - pngenc_pkg::ADLER_MOD)
                                                 : ahi_sum[15:0];
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (advance) idx_d = idx_q + 6'd1;
    if (done) busy_d = 1'b0;
    if (load) begin
      busy_d = 1'b1;
      idx_d  = (q_cmd_i.kind == pngenc_pkg::CMD_PIXEL && !q_cmd_i.row_start)
               ? pngenc_pkg::PIX_FIRST : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      ov_q   <= 1'b0;
      crc_q  <= pngenc_pkg::CRC_INIT;
      alo_q  <= 16'd1;
      ahi_q  <= 16'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      if (advance) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      if (advance) begin
        if (to_crc) crc_q <= pngenc_pkg::crc_step(crc_src, b);
        else if (crc_rst) crc_q <= pngenc_pkg::CRC_INIT;
        if (to_adl) begin
          alo_q <= alo_n;
          ahi_q <= ahi_n;
        end else if (adl_rst) begin
          alo_q <= 16'd1;
          ahi_q <= 16'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) cmd_q <= q_cmd_i;
    if (advance) begin
      byte_q <= b;
      rl_q   <= idx_q == last_idx;
      fe_q   <= is_end;
    end
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = byte_q;
  assign run_last_o  = rl_q;
  assign file_end_o  = fe_q;

endmodule

### rtl/png_stored_rgba_stream_encoder_unit.sv
// Top level: uncompressed PNG encoder for 8-bit RGBA pixel streams.
// Usage:
//  - in_i carries one transaction per item: action 0 opens a frame, action 1
//    brings one pixel (0xAARRGGBB) in raster order. Pixels outside a frame
//    are taken and dropped.
//  - out_o delivers the PNG file one byte per transaction; run_last marks the
//    last byte of an item, file_end the final byte of the file.
//  - cfg_we_i/cfg_idx_i/cfg_data_i set image width (index 0) and height
//    (index 1); write only while the block is idle. A zero reads as one.
// Timing:
//  - The front end classifies an item in its accept cycle and queues it in a
//    two-entry command queue; the back end emits one byte per cycle while out_o is ready.
//  - The first byte passes the queue, the back end's command register and the output register.
//  - A start item gives 43 bytes, a pixel 4, a row's first pixel 10, the
//    frame's last pixel 20 more; throughput is set by the back end's byte
//    rate.
// Reset: asynchronous, clears queue, frame state and checksums; width 640,
// height 480. A stalled receiver holds the output byte; the queue fills and
// then in_i ready drops.
module png_stored_rgba_stream_encoder_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pngenc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pngenc_pkg::DimW-1:0]    cfg_data_i,
  pngenc_in_if.sink                      in_i,
  pngenc_out_if.source                   out_o
);

  // Command queue hand-off
  pngenc_pkg::cmd_t push_cmd, pop_cmd;
  logic             push, pop, full, q_valid;

  pngenc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .action_i   (in_i.action),
    .pixel_i    (in_i.pixel),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_cmd_o    (push_cmd)
  );

  pngenc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (pop_cmd)
  );

  pngenc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (pop_cmd),
    .q_pop_o     (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_byte_o  (out_o.out_byte),
    .run_last_o  (out_o.run_last),
    .file_end_o  (out_o.file_end)
  );

endmodule

### tb/png_stored_rgba_stream_encoder_checker.sv
// Checker: predicts the PNG byte stream from input transactions and compares output bytes.
`timescale 1ns / 100ps
module png_stored_rgba_stream_encoder_checker
  import pngenc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [DimW-1:0]      cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 in_action_i,
  input  logic [31:0]          in_pixel_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [7:0]           out_byte_i,
  input  logic                 out_run_last_i,
  input  logic                 out_file_end_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       file_end;
  } png_byte_t;

  png_byte_t   byte_queue[$];
  logic [13:0] width_q, height_q;
  logic        in_frame;
  logic [13:0] col_q, row_q;
  logic [31:0] crc_q;
  logic [16:0] adl_lo, adl_hi;
  int          run_start;

  assign pending_o = byte_queue.size();

  function automatic logic [31:0] crc_next(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) c = c[0] ? (32'hEDB8_8320 ^ (c >> 1)) : (c >> 1);
    return c;
  endfunction

  task automatic put(input logic [7:0] b, input bit to_crc, input bit to_adler);
    png_byte_t e;
    e.data = b; e.run_last = 1'b0; e.file_end = 1'b0;
    byte_queue.push_back(e);
    if (to_crc) crc_q = crc_next(crc_q, b);
    if (to_adler) begin
      adl_lo = (adl_lo + b) % 17'd65521;
      adl_hi = (adl_hi + adl_lo) % 17'd65521;
    end
  endtask

  task automatic put_word(input logic [31:0] v, input bit to_crc);
    for (int k = 3; k >= 0; k--) put(v[8*k +: 8], to_crc, 1'b0);
  endtask

  task automatic predict_item(input logic act, input logic [31:0] px);
    logic [31:0] w, h, len;
    w = (width_q == 0) ? 1 : width_q;
    h = (height_q == 0) ? 1 : height_q;
    run_start = byte_queue.size();
    if (act == ACT_START) begin
      put(8'd137, 0, 0); put(8'd80, 0, 0); put(8'd78, 0, 0); put(8'd71, 0, 0);
      put(8'd13, 0, 0); put(8'd10, 0, 0); put(8'd26, 0, 0); put(8'd10, 0, 0);
      put_word(32'd13, 0);
      crc_q = '1;
      put_word(TAG_IHDR, 1);
      put_word(w, 1); put_word(h, 1);
      put(8'd8, 1, 0); put(8'd6, 1, 0); put(8'd0, 1, 0); put(8'd0, 1, 0); put(8'd0, 1, 0);
      put_word(~crc_q, 0);
      put_word(32'd6 + h * (4 * w + 6), 0);
      crc_q = '1;
      put_word(TAG_IDAT, 1);
      put(8'h78, 1, 0); put(8'h01, 1, 0);
      adl_lo = 1; adl_hi = 0; col_q = 0; row_q = 0; in_frame = 1'b1;
    end else if (in_frame) begin
      if (col_q == 0) begin
        len = (4 * w + 1) & 32'hFFFF;
        put((row_q + 1 >= h) ? 8'd1 : 8'd0, 1, 0);
        put(len[7:0], 1, 0); put(len[15:8], 1, 0);
        put(~len[7:0], 1, 0); put(~len[15:8], 1, 0);
        put(8'd0, 1, 1);
      end
      put(px[23:16], 1, 1); put(px[15:8], 1, 1); put(px[7:0], 1, 1); put(px[31:24], 1, 1);
      if (col_q + 1 >= w) begin
        col_q = 0;
        if (row_q + 1 >= h) begin
          row_q = 0;
          put_word({adl_hi[15:0], adl_lo[15:0]}, 1);
          put_word(~crc_q, 0);
          put_word(32'd0, 0);
          crc_q = '1;
          put_word(TAG_IEND, 1);
          put_word(~crc_q, 0);
          byte_queue[byte_queue.size()-1].file_end = 1'b1;
          in_frame = 1'b0;
        end else row_q = row_q + 1;
      end else col_q = col_q + 1;
    end
    if (byte_queue.size() > run_start) byte_queue[byte_queue.size()-1].run_last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    png_byte_t got, want;
    if (!rst_ni) begin
      byte_queue.delete();
      width_q <= WIDTH_RST; height_q <= HEIGHT_RST;
      in_frame = 1'b0; col_q = 0; row_q = 0; crc_q = '1; adl_lo = 1; adl_hi = 0;
      fail_count_o <= 0;
    end else begin
      // output side first: bytes predicted this edge cannot appear yet
      if (out_valid_i && out_ready_i) begin
        got = '{out_byte_i, out_run_last_i, out_file_end_i};
        if (byte_queue.size() == 0) begin
          $display("%0t: unexpected byte: expected none, actual %h/%b/%b", $time,
                   out_byte_i, out_run_last_i, out_file_end_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = byte_queue.pop_front();
          if (got !== want) begin
            $display("%0t: byte mismatch: expected %h/%b/%b, actual %h/%b/%b", $time,
                     want.data, want.run_last, want.file_end,
                     got.data, got.run_last, got.file_end);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_item(in_action_i, in_pixel_i);
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_WIDTH) width_q <= cfg_data_i;
        else if (cfg_idx_i == CFG_HEIGHT) height_q <= cfg_data_i;
      end
    end
  end

endmodule

### tb/tb_png_stored_rgba_stream_encoder_unit.sv
// Testbench top: drives frames of pixels into the PNG encoder and reports the verdict.
`timescale 1ns / 100ps
module tb_png_stored_rgba_stream_encoder_unit;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_we_i;
  logic [pngenc_pkg::CfgIdxW-1:0]    cfg_idx_i;
  logic [pngenc_pkg::DimW-1:0]       cfg_data_i;
  int unsigned                       fail_count;
  int unsigned                       pending;
  int unsigned                       idle_cycles;
  bit                                hold_rx;   // long receiver hold-off requested
  bit                                stim_done;

  pngenc_in_if  in_ch ();
  pngenc_out_if out_ch ();

  png_stored_rgba_stream_encoder_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch.sink),
    .out_o      (out_ch.source)
  );

  png_stored_rgba_stream_encoder_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_ch.valid),
    .in_ready_i     (in_ch.ready),
    .in_action_i    (in_ch.action),
    .in_pixel_i     (in_ch.pixel),
    .out_valid_i    (out_ch.valid),
    .out_ready_i    (out_ch.ready),
    .out_byte_i     (out_ch.out_byte),
    .out_run_last_i (out_ch.run_last),
    .out_file_end_i (out_ch.file_end),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random back-pressure; one long hold-off when asked for.
  initial begin
    int unsigned n;
    bit          held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_rx && !held) begin
        out_ch.ready <= 1'b0;
        repeat (200) @(posedge clk_i);
        held = 1'b1;
      end
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        n = gap_len();
        if (n > 0) begin
          @(posedge clk_i);
          out_ch.ready <= 1'b0;
          repeat (n - 1) @(posedge clk_i);
        end
      end
    end
  end

  // Watchdog: cycles with no transaction on either channel.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // One input transaction; gaps only when the caller allows them.
  task automatic send(input logic act, input logic [31:0] px, input bit gaps);
    int unsigned g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.pixel  <= px;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [pngenc_pkg::CfgIdxW-1:0] idx,
                           input logic [pngenc_pkg::DimW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic [31:0] rand_pixel();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // A whole frame of w*h pixels, optionally with stray noise.
  task automatic frame(input int unsigned w, input int unsigned h, input bit noisy,
                       inout int unsigned sent);
    int unsigned n;
    n = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
    send(pngenc_pkg::ACT_START, $urandom(), 1); sent++;
    for (int unsigned i = 0; i < n; i++) begin
      send(pngenc_pkg::ACT_PIXEL, rand_pixel(), 1); sent++;
      // broken sequence: an occasional restart abandons the frame
      if (noisy && $urandom_range(0, 60) == 0) return;
    end
    // stray pixels after the frame are dropped
    if (noisy && $urandom_range(0, 3) == 0) send(pngenc_pkg::ACT_PIXEL, $urandom(), 1);
  endtask

  initial begin
    int unsigned sent;
    int unsigned w, h;
    sent = 0;
    hold_rx = 1'b0;
    stim_done = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = pngenc_pkg::CFG_WIDTH;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.action = pngenc_pkg::ACT_START;
    in_ch.pixel = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: pixels with no frame, then a start under reset sizes.
    send(pngenc_pkg::ACT_PIXEL, 32'hFFFF_FFFF, 0);
    send(pngenc_pkg::ACT_PIXEL, 32'h0000_0000, 0);
    send(pngenc_pkg::ACT_START, 32'h0, 0);
    send(pngenc_pkg::ACT_PIXEL, 32'h8040_2010, 0);
    send(pngenc_pkg::ACT_START, 32'hFFFF_FFFF, 0);   // restart while a frame is open
    drain();
    // Zero sizes read as one.
    write_reg(pngenc_pkg::CFG_WIDTH, 14'd0);
    write_reg(pngenc_pkg::CFG_HEIGHT, 14'd0);
    frame(0, 0, 0, sent);
    drain();
    // Largest sizes: a start and two pixels; the LEN field still fits 16 bits.
    write_reg(pngenc_pkg::CFG_WIDTH, 14'h3FFF);
    write_reg(pngenc_pkg::CFG_HEIGHT, 14'h3FFF);
    send(pngenc_pkg::ACT_START, 32'h0, 0);
    send(pngenc_pkg::ACT_PIXEL, 32'hA5A5_5A5A, 0);
    send(pngenc_pkg::ACT_PIXEL, 32'h5A5A_A5A5, 0);
    // Index beyond the two registers.
    drain();
    write_reg(2'd3, 14'd5);
    write_reg(2'd2, 14'd7);
    write_reg(pngenc_pkg::CFG_WIDTH, 14'd1);
    write_reg(pngenc_pkg::CFG_HEIGHT, 14'd3);
    frame(1, 3, 0, sent);
    drain();

    // Pressure: receiver holds off while the sender keeps offering.
    write_reg(pngenc_pkg::CFG_WIDTH, 14'd4);
    write_reg(pngenc_pkg::CFG_HEIGHT, 14'd2);
    hold_rx = 1'b1;
    frame(4, 2, 0, sent);
    drain();   // sender pauses until every byte has come

    // Random frames, mostly small sizes; sizes change only once drained.
    w = 4;
    h = 2;
    while (sent < 480) begin
      if ($urandom_range(0, 2) == 0) begin
        drain();
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 6);
        h = $urandom_range(0, 5);
        write_reg(pngenc_pkg::CFG_WIDTH, w[13:0]);
        write_reg(pngenc_pkg::CFG_HEIGHT, h[13:0]);
      end
      frame(w, h, 1, sent);
    end
    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
